/* rtl/core/sstt_pkg.sv */
`timescale 1ns / 1ps

package sstt_pkg;

  // item kinds
  typedef logic [1:0] kind_t;
  localparam kind_t KIND_ARRIVAL  = 2'd0;
  localparam kind_t KIND_DONE     = 2'd1;
  localparam kind_t KIND_FINALISE = 2'd2;

  // result status codes
  typedef logic [1:0] status_t;
  localparam status_t STATUS_OK        = 2'd0;
  localparam status_t STATUS_FULL      = 2'd1;
  localparam status_t STATUS_IDLE_DONE = 2'd2;

  // queue control from the tracker to the wait queue
  typedef struct packed {
    logic push;
    logic pop;
  } q_ctl_t;

endpackage

/* rtl/core/sstt_ram.sv */
`timescale 1ns / 1ps

module sstt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/core/sstt_queue.sv */
`timescale 1ns / 1ps

module sstt_queue
  import sstt_pkg::*;
#(
  parameter int DEPTH = 64,
  parameter int ID_W  = 8
) (
  input  logic                       clk,
  input  logic                       rst,
  input  q_ctl_t                     ctl,
  input  logic [ID_W-1:0]            push_id,
  output logic [ID_W-1:0]            head_id,
  output logic [$clog2(DEPTH+1)-1:0] count
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int SUM_W = CNT_W + 1;

  logic [PTR_W-1:0] head;
  logic [PTR_W-1:0] head_inc;
  logic [PTR_W-1:0] head_next;
  logic [PTR_W-1:0] tail;
  logic [PTR_W-1:0] rd_addr;
  logic [SUM_W-1:0] tail_sum;
  logic [ID_W-1:0]  head_val;
  logic [ID_W-1:0]  ram_rdata;
  logic [ID_W-1:0]  nxt_data;
  logic             byp_valid;
  logic [ID_W-1:0]  byp_data;

  // pointer arithmetic with wrap at the queue depth
  assign head_inc  = (head == PTR_W'(DEPTH - 1)) ? '0 : head + PTR_W'(1);
  assign head_next = ctl.pop ? head_inc : head;
  assign tail_sum  = SUM_W'(head) + SUM_W'(count);
  assign tail      = (tail_sum >= SUM_W'(DEPTH)) ? PTR_W'(tail_sum - SUM_W'(DEPTH))
                                                 : PTR_W'(tail_sum);
  // look ahead at the entry behind the head for the next pop
  assign rd_addr   = (head_next == PTR_W'(DEPTH - 1)) ? '0 : head_next + PTR_W'(1);
  assign nxt_data  = byp_valid ? byp_data : ram_rdata;
  assign head_id   = head_val;

  sstt_ram #(
    .WIDTH (ID_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ctl.push),
    .waddr (tail),
    .wdata (push_id),
    .raddr (rd_addr),
    .rdata (ram_rdata)
  );

  // head pointer, count and write bypass flag
  always_ff @(posedge clk) begin
    if (rst) begin
      head      <= '0;
      count     <= '0;
      byp_valid <= 1'b0;
    end else begin
      head      <= head_next;
      byp_valid <= ctl.push && (tail == rd_addr);
      if (ctl.push) begin
        count <= count + CNT_W'(1);
      end else if (ctl.pop) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  // head entry held in a register, bypass data alongside
  always_ff @(posedge clk) begin
    byp_data <= push_id;
    if (ctl.push && count == '0) begin
      head_val <= push_id;
    end else if (ctl.pop && count > CNT_W'(1)) begin
      head_val <= nxt_data;
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("queue count beyond depth");

  a_no_empty_pop: assert property (@(posedge clk) disable iff (rst)
    ctl.pop |-> count != '0)
    else $error("pop from empty queue");

  a_no_full_push: assert property (@(posedge clk) disable iff (rst)
    ctl.push |-> (count != CNT_W'(DEPTH)) && !ctl.pop)
    else $error("push into full queue or with pop");

endmodule

/* rtl/core/single_server_fifo_service_tracker_top.sv */
`timescale 1ns / 1ps
// a request is accepted into the input register, and its result is then
//   registered in the result register once the result channel can advance
// throughput: one request per cycle while the result channel is not stalled, every request gives exactly one result
// reset clears all statistics, the server state and the queue pointers and
//   sets service_time to 1; queued id storage is not cleared

module single_server_fifo_service_tracker_top
  import sstt_pkg::*;
#(
  parameter int QUEUE_DEPTH = 64,
  parameter int ID_BITS     = 8
) (
  input  logic                             clk,
  input  logic                             rst,
  // configuration
  input  logic                             cfg_we,
  input  logic [15:0]                      cfg_data,
  // request channel
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [1:0]                       kind,
  input  logic [31:0]                      event_time,
  input  logic [ID_BITS-1:0]               client_id,
  // result channel
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [1:0]                       status,
  output logic [31:0]                      sched_start,
  output logic                             next_valid,
  output logic [ID_BITS-1:0]               next_client,
  output logic                             server_busy,
  output logic [31:0]                      projected_wait,
  output logic [$clog2(QUEUE_DEPTH+1)-1:0] queue_depth,
  output logic [31:0]                      served_count,
  output logic [47:0]                      busy_total,
  output logic [47:0]                      idle_total,
  output logic [$clog2(QUEUE_DEPTH+1)-1:0] peak_depth,
  output logic [47:0]                      wait_total
);

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  function automatic logic [31:0] add_sat32(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? '1 : s[31:0];
  endfunction

  function automatic logic [47:0] add_sat48(input logic [47:0] a, input logic [31:0] b);
    logic [48:0] s;
    s = {1'b0, a} + {17'b0, b};
    return s[48] ? '1 : s[47:0];
  endfunction

  function automatic logic [31:0] diff0(input logic [31:0] a, input logic [31:0] b);
    return (a > b) ? a - b : '0;
  endfunction

  // configuration register
  logic [15:0] service_time;

  // input register
  logic               s1_valid;
  kind_t              s1_kind;
  logic [31:0]        s1_time;
  logic [ID_BITS-1:0] s1_id;

  // tracker state
  logic        in_service;
  logic [31:0] free_time;
  logic [31:0] idle_since;
  logic [31:0] served_acc;
  logic [47:0] busy_acc;
  logic [47:0] idle_acc;
  logic [47:0] wait_acc;
  logic [CNT_W-1:0] peak_acc;

  // next values
  logic        in_service_next;
  logic [31:0] free_time_next;
  logic [31:0] idle_since_next;
  logic [31:0] served_acc_next;
  logic [47:0] busy_acc_next;
  logic [47:0] idle_acc_next;
  logic [47:0] wait_acc_next;
  logic [CNT_W-1:0] peak_acc_next;
  logic [CNT_W-1:0] count_next;

  // per request results
  status_t            res_status;
  logic [31:0]        res_start;
  logic               res_nvalid;
  logic [ID_BITS-1:0] res_nclient;

  logic               adv;
  logic               fire;
  q_ctl_t             q_ctl;
  logic [ID_BITS-1:0] head_id;
  logic [CNT_W-1:0]   fifo_count;
  logic [31:0]        st32;

  assign st32     = {16'b0, service_time};
  assign adv      = !out_valid || out_ready;
  assign in_ready = !s1_valid || adv;
  assign fire     = s1_valid && adv;

  sstt_queue #(
    .DEPTH (QUEUE_DEPTH),
    .ID_W  (ID_BITS)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .ctl     (q_ctl),
    .push_id (s1_id),
    .head_id (head_id),
    .count   (fifo_count)
  );

  // configuration write
  always_ff @(posedge clk) begin
    if (rst) begin
      service_time <= 16'd1;
    end else if (cfg_we) begin
      service_time <= cfg_data;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_kind <= kind;
      s1_time <= event_time;
      s1_id   <= client_id;
    end
  end

  // event processing for the request in the input register
  always_comb begin
    res_status      = STATUS_OK;
    res_start       = '0;
    res_nvalid      = 1'b0;
    res_nclient     = '0;
    in_service_next = in_service;
    free_time_next  = free_time;
    idle_since_next = idle_since;
    served_acc_next = served_acc;
    busy_acc_next   = busy_acc;
    idle_acc_next   = idle_acc;
    wait_acc_next   = wait_acc;
    peak_acc_next   = peak_acc;
    q_ctl.push      = 1'b0;
    q_ctl.pop       = 1'b0;
    case (s1_kind)
      KIND_ARRIVAL: begin
        if (!in_service) begin
          // idle server starts at once
          idle_acc_next   = add_sat48(idle_acc, diff0(s1_time, idle_since));
          in_service_next = 1'b1;
          res_start       = s1_time;
          free_time_next  = add_sat32(s1_time, st32);
          busy_acc_next   = add_sat48(busy_acc, st32);
        end else if (fifo_count == CNT_W'(QUEUE_DEPTH)) begin
          res_status = STATUS_FULL;
        end else begin
          // join the queue behind the current free time
          res_start      = free_time;
          q_ctl.push     = fire;
          free_time_next = add_sat32(free_time, st32);
          if (fifo_count + CNT_W'(1) > peak_acc) begin
            peak_acc_next = fifo_count + CNT_W'(1);
          end
          wait_acc_next = add_sat48(wait_acc, diff0(free_time, s1_time));
        end
      end
      KIND_DONE: begin
        if (!in_service) begin
          res_status = STATUS_IDLE_DONE;
        end else begin
          served_acc_next = (served_acc == '1) ? served_acc : served_acc + 32'd1;
          if (fifo_count == '0) begin
            in_service_next = 1'b0;
            idle_since_next = s1_time;
          end else begin
            // hand over to the oldest waiting client
            q_ctl.pop      = fire;
            res_nvalid     = 1'b1;
            res_nclient    = head_id;
            free_time_next = add_sat32(s1_time, st32);
            busy_acc_next  = add_sat48(busy_acc, st32);
          end
        end
      end
      KIND_FINALISE: begin
        if (!in_service) begin
          idle_acc_next = add_sat48(idle_acc, diff0(s1_time, idle_since));
        end
      end
      default: begin
      end
    endcase
    count_next = q_ctl.push ? fifo_count + CNT_W'(1) :
                 q_ctl.pop  ? fifo_count - CNT_W'(1) : fifo_count;
  end

  // state update
  always_ff @(posedge clk) begin
    if (rst) begin
      in_service <= 1'b0;
      free_time  <= '0;
      idle_since <= '0;
      served_acc <= '0;
      busy_acc   <= '0;
      idle_acc   <= '0;
      wait_acc   <= '0;
      peak_acc   <= '0;
    end else if (fire) begin
      in_service <= in_service_next;
      free_time  <= free_time_next;
      idle_since <= idle_since_next;
      served_acc <= served_acc_next;
      busy_acc   <= busy_acc_next;
      idle_acc   <= idle_acc_next;
      wait_acc   <= wait_acc_next;
      peak_acc   <= peak_acc_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      status         <= res_status;
      sched_start    <= res_start;
      next_valid     <= res_nvalid;
      next_client    <= res_nclient;
      server_busy    <= in_service_next;
      projected_wait <= diff0(free_time_next, s1_time);
      queue_depth    <= count_next;
      served_count   <= served_acc_next;
      busy_total     <= busy_acc_next;
      idle_total     <= idle_acc_next;
      peak_depth     <= peak_acc_next;
      wait_total     <= wait_acc_next;
    end
  end

  a_queue_needs_server: assert property (@(posedge clk) disable iff (rst)
    fifo_count != '0 |-> in_service)
    else $error("clients waiting while server idle");

  a_peak_covers_depth: assert property (@(posedge clk) disable iff (rst)
    peak_acc >= fifo_count)
    else $error("peak depth below current depth");

  a_handover_reports: assert property (@(posedge clk) disable iff (rst)
    q_ctl.pop |=> out_valid && next_valid && server_busy)
    else $error("hand-over not reported in result");

endmodule

/* dv/queue_stats_checker.sv */
`timescale 1ns / 1ps

module queue_stats_checker
  import sstt_pkg::*;
#(
  parameter int QUEUE_DEPTH = 64,
  parameter int ID_BITS     = 8,
  parameter int DEPTH_W     = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [15:0]        cfg_data,
  input  logic               in_valid,
  input  logic               in_ready,
  input  kind_t              kind,
  input  logic [31:0]        event_time,
  input  logic [ID_BITS-1:0] client_id,
  input  logic               out_valid,
  input  logic               out_ready,
  input  status_t            status,
  input  logic [31:0]        sched_start,
  input  logic               next_valid,
  input  logic [ID_BITS-1:0] next_client,
  input  logic               server_busy,
  input  logic [31:0]        projected_wait,
  input  logic [DEPTH_W-1:0] queue_depth,
  input  logic [31:0]        served_count,
  input  logic [47:0]        busy_total,
  input  logic [47:0]        idle_total,
  input  logic [DEPTH_W-1:0] peak_depth,
  input  logic [47:0]        wait_total,
  output int                 mismatches,
  output int                 pending,
  output int                 full_drops,
  output int                 idle_dones
);

  localparam logic [31:0] MAX32 = 32'hFFFF_FFFF;
  localparam logic [47:0] MAX48 = 48'hFFFF_FFFF_FFFF;
  localparam int REPORT_CAP = 50;

  typedef struct {
    status_t             status;
    logic [31:0]         sched_start;
    logic                next_valid;
    logic [ID_BITS-1:0]  next_client;
    logic                server_busy;
    logic [31:0]         projected_wait;
    logic [DEPTH_W-1:0]  queue_depth;
    logic [31:0]         served_count;
    logic [47:0]         busy_total;
    logic [47:0]         idle_total;
    logic [DEPTH_W-1:0]  peak_depth;
    logic [47:0]         wait_total;
  } tracker_result_t;

  // shadow copy of the server, its wait queue and the running totals
  logic [15:0]        svc_ticks;
  logic [ID_BITS-1:0] waitq [QUEUE_DEPTH];
  int                 q_head;
  int                 q_count;
  logic               busy;
  logic [ID_BITS-1:0] cur_id;
  logic [31:0]        free_at;
  logic [31:0]        idle_from;
  logic [31:0]        served_n;
  logic [47:0]        busy_sum;
  logic [47:0]        idle_sum;
  logic [47:0]        wait_sum;
  int                 depth_peak;

  tracker_result_t expected_results[$];
  int errs;
  int drops;
  int idle_hits;

  function automatic logic [31:0] add_sat32(logic [31:0] a, logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? MAX32 : s[31:0];
  endfunction

  function automatic logic [47:0] add_sat48(logic [47:0] a, logic [47:0] b);
    logic [48:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[48] ? MAX48 : s[47:0];
  endfunction

  // difference clamped at zero when time runs backwards
  function automatic logic [31:0] ahead_by(logic [31:0] a, logic [31:0] b);
    return (a > b) ? a - b : 32'h0;
  endfunction

  task automatic open_service(input logic [31:0] t);
    free_at  = add_sat32(t, {16'h0, svc_ticks});
    busy_sum = add_sat48(busy_sum, {32'h0, svc_ticks});
  endtask

  // advance the shadow server by one request and form its result
  task automatic apply_request(input kind_t k, input logic [31:0] t,
                               input logic [ID_BITS-1:0] id,
                               output tracker_result_t r);
    r = '{default: '0};
    case (k)
      KIND_ARRIVAL: begin
        if (!busy) begin
          idle_sum      = add_sat48(idle_sum, {16'h0, ahead_by(t, idle_from)});
          cur_id        = id;
          busy          = 1'b1;
          r.sched_start = t;
          open_service(t);
        end else if (q_count >= QUEUE_DEPTH) begin
          r.status = STATUS_FULL;
          drops++;
        end else begin
          r.sched_start = free_at;
          waitq[(q_head + q_count) % QUEUE_DEPTH] = id;
          q_count++;
          free_at = add_sat32(free_at, {16'h0, svc_ticks});
          if (q_count > depth_peak) depth_peak = q_count;
          wait_sum = add_sat48(wait_sum, {16'h0, ahead_by(r.sched_start, t)});
        end
      end
      KIND_DONE: begin
        if (!busy) begin
          r.status = STATUS_IDLE_DONE;
          idle_hits++;
        end else begin
          served_n = (served_n == MAX32) ? served_n : served_n + 32'd1;
          busy     = 1'b0;
          if (q_count == 0) begin
            idle_from = t;
          end else begin
            cur_id        = waitq[q_head];
            q_head        = (q_head + 1) % QUEUE_DEPTH;
            q_count--;
            busy          = 1'b1;
            r.next_valid  = 1'b1;
            r.next_client = cur_id;
            open_service(t);
          end
        end
      end
      KIND_FINALISE: begin
        if (!busy) idle_sum = add_sat48(idle_sum, {16'h0, ahead_by(t, idle_from)});
      end
      default: ;
    endcase
    r.server_busy    = busy;
    r.projected_wait = ahead_by(free_at, t);
    r.queue_depth    = DEPTH_W'(q_count);
    r.served_count   = served_n;
    r.busy_total     = busy_sum;
    r.idle_total     = idle_sum;
    r.peak_depth     = DEPTH_W'(depth_peak);
    r.wait_total     = wait_sum;
  endtask

  task automatic check_field(input string field, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      if (errs < REPORT_CAP)
        $display("%0t: %s expected %0h, got %0h", $time, field, want, got);
      errs++;
    end
  endtask

  // watch both channels, predict on each request, compare on each result
  always @(posedge clk) begin
    tracker_result_t want;
    tracker_result_t predicted;
    if (rst) begin
      svc_ticks  = 16'd1;
      q_head     = 0;
      q_count    = 0;
      busy       = 1'b0;
      cur_id     = '0;
      free_at    = '0;
      idle_from  = '0;
      served_n   = '0;
      busy_sum   = '0;
      idle_sum   = '0;
      wait_sum   = '0;
      depth_peak = 0;
      expected_results.delete();
    end else begin
      if (cfg_we) svc_ticks = cfg_data;
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          if (errs < REPORT_CAP) $display("%0t: result with nothing expected", $time);
          errs++;
        end else begin
          want = expected_results.pop_front();
          check_field("status", want.status, status);
          check_field("sched_start", want.sched_start, sched_start);
          check_field("next_valid", want.next_valid, next_valid);
          check_field("next_client", want.next_client, next_client);
          check_field("server_busy", want.server_busy, server_busy);
          check_field("projected_wait", want.projected_wait, projected_wait);
          check_field("queue_depth", want.queue_depth, queue_depth);
          check_field("served_count", want.served_count, served_count);
          check_field("busy_total", want.busy_total, busy_total);
          check_field("idle_total", want.idle_total, idle_total);
          check_field("peak_depth", want.peak_depth, peak_depth);
          check_field("wait_total", want.wait_total, wait_total);
        end
      end
      if (in_valid && in_ready) begin
        apply_request(kind, event_time, client_id, predicted);
        expected_results.push_back(predicted);
      end
    end
    pending    <= expected_results.size();
    mismatches <= errs;
    full_drops <= drops;
    idle_dones <= idle_hits;
  end

endmodule

/* dv/tb_top.sv */
`timescale 1ns / 1ps

module tb_top
  import sstt_pkg::*;
();

  localparam int QUEUE_DEPTH = 64;
  localparam int ID_BITS     = 8;
  localparam int DEPTH_W     = $clog2(QUEUE_DEPTH + 1);
  localparam int STALL_LIMIT = 1000;
  localparam kind_t KIND_UNUSED = 2'd3;
  localparam logic [31:0] TIME_MAX = 32'hFFFF_FFFF;

  typedef logic [ID_BITS-1:0] client_t;

  logic               clk;
  logic               rst        = 1'b1;
  logic               cfg_we     = 1'b0;
  logic [15:0]        cfg_data   = '0;
  logic               in_valid   = 1'b0;
  logic               in_ready;
  kind_t              kind       = KIND_ARRIVAL;
  logic [31:0]        event_time = '0;
  client_t            client_id  = '0;
  logic               out_valid;
  logic               out_ready  = 1'b0;
  status_t            status;
  logic [31:0]        sched_start;
  logic               next_valid;
  client_t            next_client;
  logic               server_busy;
  logic [31:0]        projected_wait;
  logic [DEPTH_W-1:0] queue_depth;
  logic [31:0]        served_count;
  logic [47:0]        busy_total;
  logic [47:0]        idle_total;
  logic [DEPTH_W-1:0] peak_depth;
  logic [47:0]        wait_total;

  int mismatches;
  int pending;
  int full_drops;
  int idle_dones;

  int          send_idle_pct = 16;
  int          recv_idle_pct = 58;
  int          requests_sent = 0;
  int          settings_used = 0;
  int          quiet_cycles  = 0;
  logic [15:0] svc_setting   = 16'd1;
  logic [31:0] now_ticks     = '0;

  single_server_fifo_service_tracker_top #(
    .QUEUE_DEPTH(QUEUE_DEPTH),
    .ID_BITS    (ID_BITS)
  ) u_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .kind          (kind),
    .event_time    (event_time),
    .client_id     (client_id),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .status        (status),
    .sched_start   (sched_start),
    .next_valid    (next_valid),
    .next_client   (next_client),
    .server_busy   (server_busy),
    .projected_wait(projected_wait),
    .queue_depth   (queue_depth),
    .served_count  (served_count),
    .busy_total    (busy_total),
    .idle_total    (idle_total),
    .peak_depth    (peak_depth),
    .wait_total    (wait_total)
  );

  queue_stats_checker #(
    .QUEUE_DEPTH(QUEUE_DEPTH),
    .ID_BITS    (ID_BITS)
  ) u_checker (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .kind          (kind),
    .event_time    (event_time),
    .client_id     (client_id),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .status        (status),
    .sched_start   (sched_start),
    .next_valid    (next_valid),
    .next_client   (next_client),
    .server_busy   (server_busy),
    .projected_wait(projected_wait),
    .queue_depth   (queue_depth),
    .served_count  (served_count),
    .busy_total    (busy_total),
    .idle_total    (idle_total),
    .peak_depth    (peak_depth),
    .wait_total    (wait_total),
    .mismatches    (mismatches),
    .pending       (pending),
    .full_drops    (full_drops),
    .idle_dones    (idle_dones)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // result side back-pressure
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // watchdog on cycles with no handshake on either channel
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == STALL_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // one request, with an optional random gap in front of it
  task automatic send_request(input kind_t k, input logic [31:0] t, input client_t id);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid   <= 1'b1;
    kind       <= k;
    event_time <= t;
    client_id  <= id;
    do @(posedge clk); while (!in_ready);
    requests_sent++;
  endtask

  // stop sending and wait until every result is back
  task automatic quiesce();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic set_service_time(input logic [15:0] ticks);
    quiesce();
    cfg_we   <= 1'b1;
    cfg_data <= ticks;
    @(posedge clk);
    cfg_we      <= 1'b0;
    svc_setting  = ticks;
    settings_used++;
  endtask

  function automatic logic [31:0] advance_clock(input int unsigned span);
    now_ticks = now_ticks + $urandom_range(span);
    return now_ticks;
  endfunction

  // mixed traffic: steady arrivals and completions, arrival bursts, noise
  task automatic run_batches(input int target);
    int          stop_at;
    int          pick;
    int          roll;
    int          n;
    int unsigned span;
    kind_t       k;
    stop_at = requests_sent + target;
    span    = 2 * svc_setting + 3;
    while (requests_sent < stop_at) begin
      if ($urandom_range(9) == 0) now_ticks = $urandom;
      pick = $urandom_range(99);
      if (pick < 50) begin
        // steady flow, roughly balanced arrivals and completions
        n = $urandom_range(10, 40);
        repeat (n) begin
          roll = $urandom_range(99);
          k = (roll < 50) ? KIND_ARRIVAL :
              (roll < 92) ? KIND_DONE :
              (roll < 98) ? KIND_FINALISE : KIND_UNUSED;
          send_request(k, advance_clock(span), client_t'($urandom));
        end
      end else if (pick < 80) begin
        // burst of arrivals that may overrun the queue, then a drain
        n = $urandom_range(20, 80);
        repeat (n) send_request(KIND_ARRIVAL, advance_clock(3), client_t'($urandom));
        n = $urandom_range(20, 85);
        repeat (n) send_request(KIND_DONE, advance_clock(span), client_t'($urandom));
      end else begin
        // noise: any kind, random or backward times
        n = $urandom_range(4, 12);
        repeat (n) begin
          k = kind_t'($urandom_range(3));
          if ($urandom_range(1))
            send_request(k, $urandom, client_t'($urandom));
          else
            send_request(k, now_ticks - $urandom_range(span), client_t'($urandom));
        end
      end
    end
  endtask

  // free time held at its ceiling, queued arrivals at time zero wait almost 2^32
  task automatic pin_free_time();
    set_service_time(16'hFFFF);
    // enough completions to empty the queue and free the server
    repeat (QUEUE_DEPTH + 2) send_request(KIND_DONE, TIME_MAX, client_t'($urandom));
    send_request(KIND_ARRIVAL, 32'hFFFF_0000, client_t'($urandom));
    repeat (8) send_request(KIND_ARRIVAL, 32'h0, client_t'($urandom));
    repeat (9) send_request(KIND_DONE, TIME_MAX, client_t'($urandom));
  endtask

  // stimulus and verdict
  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // directed cases with the reset service time of one tick
    send_request(KIND_FINALISE, 32'd100, 8'h00);
    send_request(KIND_DONE, 32'd110, 8'h00);
    send_request(KIND_UNUSED, 32'd120, 8'hFF);
    send_request(KIND_ARRIVAL, 32'd50, 8'hFF);
    send_request(KIND_ARRIVAL, 32'd50, 8'h00);
    send_request(KIND_ARRIVAL, 32'd200, 8'hA5);
    send_request(KIND_FINALISE, 32'd210, 8'h00);
    send_request(KIND_DONE, 32'd220, 8'h00);
    send_request(KIND_DONE, 32'd230, 8'h00);
    send_request(KIND_DONE, 32'd240, 8'h00);
    send_request(KIND_FINALISE, 32'd100, 8'h00);
    send_request(KIND_ARRIVAL, 32'd90, 8'h5A);
    send_request(KIND_DONE, 32'd300, 8'h00);
    send_request(KIND_ARRIVAL, 32'hFFFF_FFF0, 8'h3C);
    send_request(KIND_ARRIVAL, TIME_MAX, 8'hC3);
    send_request(KIND_DONE, TIME_MAX, 8'h00);
    send_request(KIND_ARRIVAL, 32'h0, 8'h81);
    send_request(KIND_DONE, TIME_MAX, 8'h00);
    send_request(KIND_DONE, TIME_MAX, 8'h00);
    send_request(KIND_FINALISE, TIME_MAX, 8'h00);
    now_ticks = '0;

    // sender idles lightly, receiver heavily
    set_service_time(16'd0);
    run_batches(200);
    set_service_time(16'hFFFF);
    run_batches(200);

    // sender idles heavily, receiver lightly
    send_idle_pct = 58;
    recv_idle_pct = 16;
    set_service_time(16'd7);
    run_batches(200);
    set_service_time(16'($urandom_range(2, 300)));
    run_batches(200);

    // full rate on both sides
    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_service_time(16'd1);
    run_batches(200);
    set_service_time(16'($urandom_range(1, 65535)));
    run_batches(200);
    pin_free_time();

    quiesce();
    repeat (4) @(posedge clk);
    $display("Run covered %0d requests over %0d service time settings and three idling profiles,",
             requests_sent, settings_used + 1);
    $display("with %0d full-queue drops, %0d idle completions and free time at its ceiling.",
             full_drops, idle_dones);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
